/* hw/rtl/whp_pkg.sv */
// Package for the wave header parser: status codes, one-hot phase type,
// chunk ids and fixed header byte counts. No dependencies.
`default_nettype none

package whp_pkg;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_DONE    = 3'd1,
        ST_READ    = 3'd2,
        ST_ID      = 3'd3,
        ST_MISSING = 3'd4
    } t_status;

    typedef enum logic [9:0] {
        PH_HDR   = 10'b00_0000_0001,
        PH_SKIP1 = 10'b00_0000_0010,
        PH_CHDR1 = 10'b00_0000_0100,
        PH_FMT   = 10'b00_0000_1000,
        PH_EXT   = 10'b00_0001_0000,
        PH_SKIPF = 10'b00_0010_0000,
        PH_DHDR  = 10'b00_0100_0000,
        PH_SKIP2 = 10'b00_1000_0000,
        PH_CHDR2 = 10'b01_0000_0000,
        PH_END   = 10'b10_0000_0000
    } t_phase;

    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;

    localparam logic [31:0] HDR_LAST   = 32'd19;
    localparam logic [31:0] CHDR_LAST  = 32'd7;
    localparam logic [31:0] FMT_BYTES  = 32'd16;
    localparam logic [31:0] FMT_LAST   = 32'd15;
    localparam logic [31:0] EXT_BYTES  = 32'd10;
    localparam logic [31:0] EXT_LAST   = 32'd9;
    localparam logic [31:0] FMT_EXT_BYTES = 32'd26;

endpackage

`default_nettype wire

/* hw/rtl/wave_header_parser_top.sv */
// Wave header parser top level: byte-stream RIFF/WAVE header decode.
// Depends on whp_pkg.
//
// channel | direction | handshake          | payload
// in      | sink      | i_valid / o_stall  | i_data_byte, i_stream_end
// out     | source    | o_valid / i_stall  | o_status and parsed header fields
//
// One beat in, one beat out; sustained rate is one beat per cycle while i_stall is low.
// A byte passes the input register, then the header-state update into the
// result register. The single state update per byte sets that rate.
// Reset (synchronous, active low) clears the parser to expect the RIFF id.
// A stalled result holds the result register; the input register keeps
// accepting until it is full behind it.
`default_nettype none

module wave_header_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_stream_end,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [15:0]      o_format,
    output logic [15:0]      o_channels,
    output logic [31:0]      o_sample_rate,
    output logic [31:0]      o_byte_rate,
    output logic [15:0]      o_block_align,
    output logic [15:0]      o_bits_per_sample,
    output logic [15:0]      o_valid_bits,
    output logic [31:0]      o_channel_mask,
    output logic [15:0]      o_sub_format,
    output logic [31:0]      o_data_size
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_end;
    logic             w_advance;

    whp_pkg::t_phase  r_phase, n_phase;
    whp_pkg::t_status r_status, n_status;
    logic [31:0]      r_count, n_count;
    logic [31:0]      r_id, n_id;
    logic [31:0]      r_len, n_len;
    logic             r_hdr_ok, n_hdr_ok;
    logic [15:0]      r_format, n_format;
    logic [15:0]      r_channels, n_channels;
    logic [31:0]      r_rate, n_rate;
    logic [31:0]      r_byte_rate, n_byte_rate;
    logic [15:0]      r_align, n_align;
    logic [15:0]      r_bits, n_bits;
    logic [15:0]      r_vbits, n_vbits;
    logic [31:0]      r_mask, n_mask;
    logic [15:0]      r_sub, n_sub;
    logic [31:0]      r_dsize, n_dsize;

    logic [31:0]      w_id_push;
    logic [31:0]      w_len_push;
    logic [31:0]      w_cnt_inc;
    logic [31:0]      w_fmt_rest;
    logic [31:0]      w_ext_rest;
    logic             w_done;

    assign w_advance = r_in_valid && (!o_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_stream_end;
        end
    end

    assign w_id_push  = {r_in_byte, r_id[31:8]};
    assign w_len_push = {r_in_byte, r_len[31:8]};
    assign w_cnt_inc  = r_count + 32'd1;
    assign w_fmt_rest = r_len - whp_pkg::FMT_BYTES;
    assign w_ext_rest = r_len - whp_pkg::FMT_EXT_BYTES;

    always_comb begin
        n_phase     = r_phase;
        n_status    = r_status;
        n_count     = r_count;
        n_id        = r_id;
        n_len       = r_len;
        n_hdr_ok    = r_hdr_ok;
        n_format    = r_format;
        n_channels  = r_channels;
        n_rate      = r_rate;
        n_byte_rate = r_byte_rate;
        n_align     = r_align;
        n_bits      = r_bits;
        n_vbits     = r_vbits;
        n_mask      = r_mask;
        n_sub       = r_sub;
        n_dsize     = r_dsize;
        if (r_status == whp_pkg::ST_BUSY) begin
            if (r_in_end) begin
                if (r_phase == whp_pkg::PH_SKIP1 || r_phase == whp_pkg::PH_CHDR1 ||
                    r_phase == whp_pkg::PH_SKIP2 || r_phase == whp_pkg::PH_CHDR2) begin
                    n_status = whp_pkg::ST_MISSING;
                end else begin
                    n_status = whp_pkg::ST_READ;
                end
                n_phase = whp_pkg::PH_END;
            end else begin
                unique case (r_phase)
                    whp_pkg::PH_HDR: begin
                        if (r_count < 32'd4 || (r_count >= 32'd8 && r_count < 32'd16)) begin
                            n_id = w_id_push;
                        end else if (r_count >= 32'd16) begin
                            n_len = w_len_push;
                        end
                        if (r_count == 32'd3 && w_id_push != whp_pkg::ID_RIFF) begin
                            n_hdr_ok = 1'b0;
                        end
                        if (r_count == 32'd11 && w_id_push != whp_pkg::ID_WAVE) begin
                            n_hdr_ok = 1'b0;
                        end
                        n_count = w_cnt_inc;
                        if (r_count == whp_pkg::HDR_LAST) begin
                            if (!r_hdr_ok) begin
                                n_status = whp_pkg::ST_ID;
                                n_phase  = whp_pkg::PH_END;
                            end else if (r_id == whp_pkg::ID_FMT) begin
                                n_phase = whp_pkg::PH_FMT;
                                n_count = '0;
                            end else if (w_len_push == '0) begin
                                n_phase = whp_pkg::PH_CHDR1;
                                n_count = '0;
                            end else begin
                                n_phase = whp_pkg::PH_SKIP1;
                                n_count = w_len_push;
                            end
                        end
                    end
                    whp_pkg::PH_SKIP1, whp_pkg::PH_SKIP2, whp_pkg::PH_SKIPF: begin
                        n_count = r_count - 32'd1;
                        if (n_count == '0) begin
                            if (r_phase == whp_pkg::PH_SKIP1) begin
                                n_phase = whp_pkg::PH_CHDR1;
                            end else if (r_phase == whp_pkg::PH_SKIP2) begin
                                n_phase = whp_pkg::PH_CHDR2;
                            end else begin
                                n_phase = whp_pkg::PH_DHDR;
                            end
                        end
                    end
                    whp_pkg::PH_CHDR1: begin
                        if (r_count < 32'd4) begin
                            n_id = w_id_push;
                        end else begin
                            n_len = w_len_push;
                        end
                        n_count = w_cnt_inc;
                        if (r_count == whp_pkg::CHDR_LAST) begin
                            if (r_id == whp_pkg::ID_FMT) begin
                                n_phase = whp_pkg::PH_FMT;
                                n_count = '0;
                            end else if (w_len_push == '0) begin
                                n_phase = whp_pkg::PH_CHDR1;
                                n_count = '0;
                            end else begin
                                n_phase = whp_pkg::PH_SKIP1;
                                n_count = w_len_push;
                            end
                        end
                    end
                    whp_pkg::PH_FMT: begin
                        if (r_count < 32'd2) begin
                            n_format = {r_in_byte, r_format[15:8]};
                        end else if (r_count < 32'd4) begin
                            n_channels = {r_in_byte, r_channels[15:8]};
                        end else if (r_count < 32'd8) begin
                            n_rate = {r_in_byte, r_rate[31:8]};
                        end else if (r_count < 32'd12) begin
                            n_byte_rate = {r_in_byte, r_byte_rate[31:8]};
                        end else if (r_count < 32'd14) begin
                            n_align = {r_in_byte, r_align[15:8]};
                        end else begin
                            n_bits = {r_in_byte, r_bits[15:8]};
                        end
                        n_count = w_cnt_inc;
                        if (r_count == whp_pkg::FMT_LAST) begin
                            if (r_len > whp_pkg::FMT_BYTES) begin
                                if (r_format == whp_pkg::FMT_EXTENSIBLE &&
                                    r_len >= whp_pkg::FMT_EXT_BYTES) begin
                                    n_phase = whp_pkg::PH_EXT;
                                    n_count = '0;
                                end else begin
                                    n_phase = whp_pkg::PH_SKIPF;
                                    n_count = w_fmt_rest;
                                end
                            end else begin
                                n_phase = whp_pkg::PH_DHDR;
                                n_count = '0;
                            end
                        end
                    end
                    whp_pkg::PH_EXT: begin
                        if (r_count >= 32'd2 && r_count < 32'd4) begin
                            n_vbits = {r_in_byte, r_vbits[15:8]};
                        end else if (r_count >= 32'd4 && r_count < 32'd8) begin
                            n_mask = {r_in_byte, r_mask[31:8]};
                        end else if (r_count >= 32'd8) begin
                            n_sub = {r_in_byte, r_sub[15:8]};
                        end
                        n_count = w_cnt_inc;
                        if (r_count == whp_pkg::EXT_LAST) begin
                            if (w_ext_rest == '0) begin
                                n_phase = whp_pkg::PH_DHDR;
                                n_count = '0;
                            end else begin
                                n_phase = whp_pkg::PH_SKIPF;
                                n_count = w_ext_rest;
                            end
                        end
                    end
                    whp_pkg::PH_DHDR, whp_pkg::PH_CHDR2: begin
                        if (r_count < 32'd4) begin
                            n_id = w_id_push;
                        end else begin
                            n_len = w_len_push;
                        end
                        n_count = w_cnt_inc;
                        if (r_count == whp_pkg::CHDR_LAST) begin
                            if (r_id == whp_pkg::ID_DATA) begin
                                n_dsize  = w_len_push;
                                n_status = whp_pkg::ST_DONE;
                                n_phase  = whp_pkg::PH_END;
                            end else if (w_len_push == '0) begin
                                n_phase = whp_pkg::PH_CHDR2;
                                n_count = '0;
                            end else begin
                                n_phase = whp_pkg::PH_SKIP2;
                                n_count = w_len_push;
                            end
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    assign w_done = (n_status == whp_pkg::ST_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= whp_pkg::PH_HDR;
            r_status    <= whp_pkg::ST_BUSY;
            r_count     <= '0;
            r_id        <= '0;
            r_len       <= '0;
            r_hdr_ok    <= 1'b1;
            r_format    <= '0;
            r_channels  <= '0;
            r_rate      <= '0;
            r_byte_rate <= '0;
            r_align     <= '0;
            r_bits      <= '0;
            r_vbits     <= '0;
            r_mask      <= '0;
            r_sub       <= '0;
            r_dsize     <= '0;
        end else if (w_advance) begin
            r_phase     <= n_phase;
            r_status    <= n_status;
            r_count     <= n_count;
            r_id        <= n_id;
            r_len       <= n_len;
            r_hdr_ok    <= n_hdr_ok;
            r_format    <= n_format;
            r_channels  <= n_channels;
            r_rate      <= n_rate;
            r_byte_rate <= n_byte_rate;
            r_align     <= n_align;
            r_bits      <= n_bits;
            r_vbits     <= n_vbits;
            r_mask      <= n_mask;
            r_sub       <= n_sub;
            r_dsize     <= n_dsize;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_advance) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            o_status          <= n_status;
            o_format          <= w_done ? n_format    : '0;
            o_channels        <= w_done ? n_channels  : '0;
            o_sample_rate     <= w_done ? n_rate      : '0;
            o_byte_rate       <= w_done ? n_byte_rate : '0;
            o_block_align     <= w_done ? n_align     : '0;
            o_bits_per_sample <= w_done ? n_bits      : '0;
            o_valid_bits      <= w_done ? n_vbits     : '0;
            o_channel_mask    <= w_done ? n_mask      : '0;
            o_sub_format      <= w_done ? n_sub       : '0;
            o_data_size       <= w_done ? n_dsize     : '0;
        end
    end

    a_status_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != whp_pkg::ST_BUSY) |=> (r_status == $past(r_status)))
        else $error("final status changed");

    a_end_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == whp_pkg::ST_BUSY) == (r_phase != whp_pkg::PH_END))
        else $error("end phase and status disagree");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == whp_pkg::PH_SKIP1 || r_phase == whp_pkg::PH_SKIP2 ||
         r_phase == whp_pkg::PH_SKIPF) |-> (r_count != '0))
        else $error("skip phase with empty count");

    a_fields_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != whp_pkg::ST_DONE) |->
        (o_format == '0 && o_sample_rate == '0 && o_data_size == '0))
        else $error("fields shown before done");

endmodule

`default_nettype wire

/* dv/wave_header_parser_top_test.sv */
`timescale 1ns / 100ps
// Testbench for wave_header_parser_top: streams one RIFF/WAVE byte file with random
// idling on both channels and checks each result beat against a behavioral parser
// kept in a scoreboard class. Depends on whp_pkg and wave_header_parser_top.

typedef struct packed {
    whp_pkg::t_status status;
    logic [15:0]      format;
    logic [15:0]      channels;
    logic [31:0]      sample_rate;
    logic [31:0]      byte_rate;
    logic [15:0]      block_align;
    logic [15:0]      bits_per_sample;
    logic [15:0]      valid_bits;
    logic [31:0]      channel_mask;
    logic [15:0]      sub_format;
    logic [31:0]      data_size;
} t_header_beat;

class header_scoreboard;
    whp_pkg::t_phase  phase;
    logic [31:0]      pos_count;
    logic [31:0]      chunk_id;
    logic [31:0]      chunk_len;
    bit               ids_ok;
    whp_pkg::t_status parse_status;
    t_header_beat     fields;
    t_header_beat     expected_beats[$];
    int               errors;
    int               checked;

    function new();
        phase = whp_pkg::PH_HDR;
        pos_count = '0;
        chunk_id = '0;
        chunk_len = '0;
        ids_ok = 1'b1;
        parse_status = whp_pkg::ST_BUSY;
        fields = '0;
        errors = 0;
        checked = 0;
    endfunction

    function int pending();
        return expected_beats.size();
    endfunction

    function void begin_skip(whp_pkg::t_phase skip_ph, whp_pkg::t_phase next_ph,
                             logic [31:0] len);
        if (len == 0) begin
            phase = next_ph;
            pos_count = '0;
        end else begin
            phase = skip_ph;
            pos_count = len;
        end
    endfunction

    function bit chunk_header_done(logic [7:0] b);
        if (pos_count < 4)
            chunk_id = {b, chunk_id[31:8]};
        else
            chunk_len = {b, chunk_len[31:8]};
        pos_count++;
        return pos_count > whp_pkg::CHDR_LAST;
    endfunction

    function void seek_fmt();
        if (chunk_id == whp_pkg::ID_FMT) begin
            phase = whp_pkg::PH_FMT;
            pos_count = '0;
        end else begin
            begin_skip(whp_pkg::PH_SKIP1, whp_pkg::PH_CHDR1, chunk_len);
        end
    endfunction

    function void seek_data();
        if (chunk_id == whp_pkg::ID_DATA) begin
            fields.data_size = chunk_len;
            parse_status = whp_pkg::ST_DONE;
            phase = whp_pkg::PH_END;
        end else begin
            begin_skip(whp_pkg::PH_SKIP2, whp_pkg::PH_CHDR2, chunk_len);
        end
    endfunction

    function void parse_byte(logic [7:0] b);
        logic [31:0] pos;
        pos = pos_count;
        case (phase)
            whp_pkg::PH_HDR: begin
                if (pos < 4 || (pos >= 8 && pos < 16))
                    chunk_id = {b, chunk_id[31:8]};
                else if (pos >= 16)
                    chunk_len = {b, chunk_len[31:8]};
                if (pos == 3 && chunk_id != whp_pkg::ID_RIFF)
                    ids_ok = 1'b0;
                if (pos == 11 && chunk_id != whp_pkg::ID_WAVE)
                    ids_ok = 1'b0;
                pos_count = pos + 1;
                if (pos == whp_pkg::HDR_LAST) begin
                    if (!ids_ok) begin
                        parse_status = whp_pkg::ST_ID;
                        phase = whp_pkg::PH_END;
                    end else begin
                        seek_fmt();
                    end
                end
            end
            whp_pkg::PH_SKIP1, whp_pkg::PH_SKIP2, whp_pkg::PH_SKIPF: begin
                pos_count = pos - 1;
                if (pos_count == 0) begin
                    if (phase == whp_pkg::PH_SKIP1)
                        phase = whp_pkg::PH_CHDR1;
                    else if (phase == whp_pkg::PH_SKIP2)
                        phase = whp_pkg::PH_CHDR2;
                    else
                        phase = whp_pkg::PH_DHDR;
                end
            end
            whp_pkg::PH_CHDR1: begin
                if (chunk_header_done(b))
                    seek_fmt();
            end
            whp_pkg::PH_FMT: begin
                if (pos < 2)
                    fields.format = {b, fields.format[15:8]};
                else if (pos < 4)
                    fields.channels = {b, fields.channels[15:8]};
                else if (pos < 8)
                    fields.sample_rate = {b, fields.sample_rate[31:8]};
                else if (pos < 12)
                    fields.byte_rate = {b, fields.byte_rate[31:8]};
                else if (pos < 14)
                    fields.block_align = {b, fields.block_align[15:8]};
                else
                    fields.bits_per_sample = {b, fields.bits_per_sample[15:8]};
                pos_count = pos + 1;
                if (pos_count >= whp_pkg::FMT_BYTES) begin
                    if (chunk_len > whp_pkg::FMT_BYTES) begin
                        if (fields.format == whp_pkg::FMT_EXTENSIBLE &&
                            chunk_len >= whp_pkg::FMT_EXT_BYTES) begin
                            phase = whp_pkg::PH_EXT;
                            pos_count = '0;
                        end else begin
                            begin_skip(whp_pkg::PH_SKIPF, whp_pkg::PH_DHDR,
                                       chunk_len - whp_pkg::FMT_BYTES);
                        end
                    end else begin
                        phase = whp_pkg::PH_DHDR;
                        pos_count = '0;
                    end
                end
            end
            whp_pkg::PH_EXT: begin
                if (pos >= 2 && pos < 4)
                    fields.valid_bits = {b, fields.valid_bits[15:8]};
                else if (pos >= 4 && pos < 8)
                    fields.channel_mask = {b, fields.channel_mask[31:8]};
                else if (pos >= 8)
                    fields.sub_format = {b, fields.sub_format[15:8]};
                pos_count = pos + 1;
                if (pos_count >= whp_pkg::EXT_BYTES)
                    begin_skip(whp_pkg::PH_SKIPF, whp_pkg::PH_DHDR,
                               chunk_len - whp_pkg::FMT_EXT_BYTES);
            end
            whp_pkg::PH_DHDR, whp_pkg::PH_CHDR2: begin
                if (chunk_header_done(b))
                    seek_data();
            end
            default: ;
        endcase
    endfunction

    function void note_input(logic [7:0] b, logic stream_end);
        t_header_beat beat;
        if (parse_status == whp_pkg::ST_BUSY) begin
            if (stream_end) begin
                if (phase == whp_pkg::PH_SKIP1 || phase == whp_pkg::PH_CHDR1 ||
                    phase == whp_pkg::PH_SKIP2 || phase == whp_pkg::PH_CHDR2)
                    parse_status = whp_pkg::ST_MISSING;
                else
                    parse_status = whp_pkg::ST_READ;
                phase = whp_pkg::PH_END;
            end else begin
                parse_byte(b);
            end
        end
        if (parse_status == whp_pkg::ST_DONE)
            beat = fields;
        else
            beat = '0;
        beat.status = parse_status;
        expected_beats.push_back(beat);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_header_beat got);
        t_header_beat want;
        if (expected_beats.size() == 0) begin
            $error("result beat with no input beat pending");
            errors++;
            return;
        end
        want = expected_beats.pop_front();
        checked++;
        compare("status", want.status, got.status);
        compare("format", want.format, got.format);
        compare("channels", want.channels, got.channels);
        compare("sample_rate", want.sample_rate, got.sample_rate);
        compare("byte_rate", want.byte_rate, got.byte_rate);
        compare("block_align", want.block_align, got.block_align);
        compare("bits_per_sample", want.bits_per_sample, got.bits_per_sample);
        compare("valid_bits", want.valid_bits, got.valid_bits);
        compare("channel_mask", want.channel_mask, got.channel_mask);
        compare("sub_format", want.sub_format, got.sub_format);
        compare("data_size", want.data_size, got.data_size);
    endfunction
endclass

module wave_header_parser_top_test;

    localparam int STUCK_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_stream_end = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [15:0] o_format;
    logic [15:0] o_channels;
    logic [31:0] o_sample_rate;
    logic [31:0] o_byte_rate;
    logic [15:0] o_block_align;
    logic [15:0] o_bits_per_sample;
    logic [15:0] o_valid_bits;
    logic [31:0] o_channel_mask;
    logic [15:0] o_sub_format;
    logic [31:0] o_data_size;

    header_scoreboard sb;
    logic [8:0]       file_beats[$];
    int               fmt_start = 0;
    int               stuck_cycles = 0;
    int               stall_hold = 0;

    always #5 i_clk = ~i_clk;

    wave_header_parser_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_stream_end      (i_stream_end),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_format          (o_format),
        .o_channels        (o_channels),
        .o_sample_rate     (o_sample_rate),
        .o_byte_rate       (o_byte_rate),
        .o_block_align     (o_block_align),
        .o_bits_per_sample (o_bits_per_sample),
        .o_valid_bits      (o_valid_bits),
        .o_channel_mask    (o_channel_mask),
        .o_sub_format      (o_sub_format),
        .o_data_size       (o_data_size)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic void push_byte(logic [7:0] b);
        file_beats.push_back({1'b0, b});
    endfunction

    function automatic void push_end();
        file_beats.push_back({1'b1, 8'($urandom())});
    endfunction

    function automatic void push_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            push_byte(w[8 * i +: 8]);
    endfunction

    function automatic void push_filler_chunk(logic [31:0] target);
        logic [31:0] id;
        logic [31:0] len;
        int          r;
        r = $urandom_range(0, 9);
        if (r == 0)
            id = (target == whp_pkg::ID_FMT) ? whp_pkg::ID_DATA : whp_pkg::ID_FMT;
        else if (r == 1)
            id = target ^ (32'h1 << $urandom_range(0, 31));
        else
            id = $urandom();
        if (id == target)
            id[0] = ~id[0];
        r = $urandom_range(0, 99);
        if (r < 15)
            len = 0;
        else if (r < 95)
            len = $urandom_range(1, 24);
        else
            len = $urandom_range(60, 120);
        push_word(id);
        push_word(len);
        for (int i = 0; i < len; i++)
            push_byte(8'($urandom()));
    endfunction

    function automatic void build_file();
        int          variant;
        int          fill_mode;
        int          fmt_len;
        int          mode;
        int          cut;
        int          idx;
        logic [31:0] size_word;
        push_word(whp_pkg::ID_RIFF);
        push_word($urandom());
        push_word(whp_pkg::ID_WAVE);
        if ($urandom_range(0, 9) >= 3)
            while (file_beats.size() < 250)
                push_filler_chunk(whp_pkg::ID_FMT);
        fmt_start = file_beats.size();
        variant = $urandom_range(0, 3);
        case (variant)
            0: fmt_len = 16;
            1: fmt_len = $urandom_range(17, 40);
            2: fmt_len = $urandom_range(26, 48);
            default: fmt_len = $urandom_range(17, 25);
        endcase
        push_word(whp_pkg::ID_FMT);
        push_word(fmt_len);
        fill_mode = $urandom_range(0, 3);
        for (int i = 0; i < 16; i++) begin
            if (variant >= 2 && i < 2)
                push_byte(whp_pkg::FMT_EXTENSIBLE[8 * i +: 8]);
            else if (fill_mode == 0)
                push_byte(8'h00);
            else if (fill_mode == 1)
                push_byte(8'hFF);
            else
                push_byte(8'($urandom()));
        end
        for (int i = 16; i < fmt_len; i++)
            push_byte(8'($urandom()));
        if ($urandom_range(0, 9) >= 2)
            while (file_beats.size() < 640)
                push_filler_chunk(whp_pkg::ID_DATA);
        push_word(whp_pkg::ID_DATA);
        case ($urandom_range(0, 3))
            0: size_word = 32'h0000_0000;
            1: size_word = 32'hFFFF_FFFF;
            default: size_word = $urandom();
        endcase
        push_word(size_word);

        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            idx = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(8, 11);
            file_beats[idx] = file_beats[idx] ^ (9'd1 << $urandom_range(0, 7));
        end else if (mode <= 2) begin
            if ($urandom_range(0, 3) == 0)
                cut = $urandom_range(0, 19);
            else
                cut = $urandom_range(20, file_beats.size() - 1);
            while (file_beats.size() > cut)
                void'(file_beats.pop_back());
            push_end();
        end
        // trailing beats land after the verdict and must be ignored
        push_end();
        push_byte(8'($urandom()));
        push_end();
        while (file_beats.size() < 700) begin
            if ($urandom_range(0, 3) == 0)
                push_end();
            else
                push_byte(8'($urandom()));
        end
    endfunction

    always @(posedge i_clk) begin
        int stall_len;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if (i_stall) begin
            i_stall <= 1'b0;
            stall_hold <= ($urandom_range(0, 19) == 0) ? 80 : $urandom_range(0, 10);
        end else begin
            stall_len = idle_len();
            if (stall_len != 0) begin
                i_stall <= 1'b1;
                stall_hold <= stall_len - 1;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_header_beat seen;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_input(i_data_byte, i_stream_end);
            if (o_valid && !i_stall) begin
                seen.status = whp_pkg::t_status'(o_status);
                seen.format = o_format;
                seen.channels = o_channels;
                seen.sample_rate = o_sample_rate;
                seen.byte_rate = o_byte_rate;
                seen.block_align = o_block_align;
                seen.bits_per_sample = o_bits_per_sample;
                seen.valid_bits = o_valid_bits;
                seen.channel_mask = o_channel_mask;
                seen.sub_format = o_sub_format;
                seen.data_size = o_data_size;
                sb.check_result(seen);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", STUCK_LIMIT);
                $display("wave_header_parser_top_test: errors");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int gap;
        int burst_left;
        sb = new();
        burst_left = 0;
        build_file();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < file_beats.size(); k++) begin
            i_valid <= 1'b1;
            i_data_byte <= file_beats[k][7:0];
            i_stream_end <= file_beats[k][8];
            @(posedge i_clk);
            while (o_stall)
                @(posedge i_clk);
            if (k == fmt_start || k == file_beats.size() / 2 || $urandom_range(0, 199) == 0) begin
                // hold off until the result side has drained
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0)
                    @(posedge i_clk);
            end else begin
                if (burst_left > 0) begin
                    gap = 0;
                    burst_left--;
                end else begin
                    gap = idle_len();
                    if ($urandom_range(0, 49) == 0)
                        burst_left = $urandom_range(20, 60);
                end
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("streamed %0d input beats, fmt chunk header at byte %0d, %0d results checked",
                 file_beats.size(), fmt_start, sb.checked);
        $display("parser ended in status %s with %0d mismatches",
                 sb.parse_status.name(), sb.errors);
        if (sb.errors == 0)
            $display("wave_header_parser_top_test: clean");
        else
            $display("wave_header_parser_top_test: errors");
        $finish;
    end

endmodule

/* wave_header_parser_top.f */
hw/rtl/whp_pkg.sv
hw/rtl/wave_header_parser_top.sv
dv/wave_header_parser_top_test.sv
